// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used across the tracker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every rising edge outside reset
`define ASSERT_CHECK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: %m");

// Check that a condition never occurs outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
   `ASSERT_CHECK(label, clk, rst, !(expr))

`endif

// ===== src/ept_pkg.sv =====
// ---------------------------------------------------------------------------
// Encoder tracker package
// Request codes, internal command types and the execute snapshot.
// ---------------------------------------------------------------------------
package ept_pkg;

   // Request codes carried on req_tuser
   localparam logic [2:0] REQ_TICK    = 3'd0;
   localparam logic [2:0] REQ_CAPTURE = 3'd1;
   localparam logic [2:0] REQ_SET     = 3'd2;
   localparam logic [2:0] REQ_ADD     = 3'd3;
   localparam logic [2:0] REQ_ENABLE  = 3'd4;
   localparam logic [2:0] REQ_DISABLE = 3'd5;

   // Depth of the command queue between front and execute
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      OP_TICK,
      OP_CAPTURE,
      OP_SET,
      OP_ADD,
      OP_ENABLE,
      OP_DISABLE,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] hw_count;
      logic [31:0] value;
   } cmd_type;

   // State after one item, handed to the output stage
   typedef struct packed {
      logic [31:0] accum;
      logic [31:0] offset;
      logic [31:0] index_base;
      logic [31:0] vel_diff;
      logic        index_seen;
      logic [15:0] steps;
      logic [31:0] offset_change;
   } snap_type;

   function automatic logic [31:0] sext16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

endpackage

// ===== src/ept_front.sv =====
// ---------------------------------------------------------------------------
// Encoder tracker front end
// Accepts request items and classifies them into internal commands.
// ---------------------------------------------------------------------------
module ept_front
   import ept_pkg::*;
(
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        q_full,
   output logic        q_push,
   output cmd_type     q_cmd
);

   op_type op;

   // Decode the request kind
   always_comb begin
      unique case (req_tuser)
         REQ_TICK:    op = OP_TICK;
         REQ_CAPTURE: op = OP_CAPTURE;
         REQ_SET:     op = OP_SET;
         REQ_ADD:     op = OP_ADD;
         REQ_ENABLE:  op = OP_ENABLE;
         REQ_DISABLE: op = OP_DISABLE;
         default:     op = OP_NONE;
      endcase
   end

   // Take an item whenever the queue has room and reset is low
   assign req_tready     = !q_full && !reset;
   assign q_push         = req_tvalid && req_tready;
   assign q_cmd.op       = op;
   assign q_cmd.hw_count = req_tdata[15:0];
   assign q_cmd.value    = req_tdata[47:16];

endmodule

// ===== src/ept_queue.sv =====
// ---------------------------------------------------------------------------
// Encoder tracker command queue
// Short queue that decouples the front end from the execute stage.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ept_queue
   import ept_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_cmd
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = slot_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `ASSERT_NEVER(a_no_push_full, clock, reset, push && full)
   `ASSERT_NEVER(a_no_pop_empty, clock, reset, pop && !pop_valid)

endmodule

// ===== src/ept_exec.sv =====
// ---------------------------------------------------------------------------
// Encoder tracker execute stage
// Applies one command per cycle, barring stalls, to position, index, velocity.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ept_exec
   import ept_pkg::*;
#(
   parameter int HISTORY_DEPTH = 8
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     cmd_valid,
   input  cmd_type  cmd,
   output logic     cmd_pop,
   output logic     snap_valid,
   input  logic     snap_ready,
   output snap_type snap
);

   localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

   // Architectural state
   logic [31:0]      accum_ff,    accum_in;
   logic [31:0]      offset_ff,   offset_in;
   logic [15:0]      last_hw_ff,  last_hw_in;
   logic [PTR_W-1:0] ptr_ff,      ptr_in;
   logic             enabled_ff,  enabled_in;
   logic             pending_ff,  pending_in;
   logic [15:0]      capture_ff,  capture_in;
   logic [31:0]      base_ff,     base_in;
   logic             seen_ff,     seen_in;
   logic [31:0]      diff_ff,     diff_in;
   logic [15:0]      steps_ff,    steps_in;

   // Ring of past positions: memory plus per-entry valid flags and seed
   logic [31:0]      ring_mem [HISTORY_DEPTH];
   logic             ring_valid_ff [HISTORY_DEPTH];
   logic [31:0]      seed_ff,     seed_in;
   logic [31:0]      head_data_ff;
   logic             head_valid_ff;

   logic             snap_valid_ff;
   snap_type         snap_ff, snap_in;

   logic             fire;
   logic             ring_we;
   logic             ring_clear;
   logic [PTR_W-1:0] ptr_next;
   logic [PTR_W-1:0] rd_addr;
   logic [15:0]      steps_calc;
   logic [31:0]      accum_tick;
   logic [31:0]      ring_old;
   logic [31:0]      new_offset;
   logic [31:0]      change;

   assign fire       = cmd_valid && (!snap_valid_ff || snap_ready);
   assign cmd_pop    = fire;
   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

   assign ptr_next   = (ptr_ff == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
   assign steps_calc = cmd.hw_count - last_hw_ff;
   assign accum_tick = accum_ff + sext16(steps_calc);
   assign ring_old   = head_valid_ff ? head_data_ff : seed_ff;
   assign new_offset = cmd.value - accum_ff;

   // Work out the next state for the command at the head of the queue
   always_comb begin
      accum_in   = accum_ff;
      offset_in  = offset_ff;
      last_hw_in = last_hw_ff;
      ptr_in     = ptr_ff;
      enabled_in = enabled_ff;
      pending_in = pending_ff;
      capture_in = capture_ff;
      base_in    = base_ff;
      seen_in    = seen_ff;
      diff_in    = diff_ff;
      steps_in   = steps_ff;
      seed_in    = seed_ff;
      change     = '0;
      ring_we    = 1'b0;
      ring_clear = 1'b0;
      if (fire) begin
         unique case (cmd.op)
            OP_TICK: begin
               if (enabled_ff) begin
                  steps_in   = steps_calc;
                  seen_in    = pending_ff;
                  if (pending_ff) begin
                     base_in    = accum_ff + sext16(capture_ff) - sext16(last_hw_ff);
                     pending_in = 1'b0;
                  end
                  last_hw_in = cmd.hw_count;
                  accum_in   = accum_tick;
                  diff_in    = accum_tick - ring_old;
                  ring_we    = 1'b1;
                  ptr_in     = ptr_next;
               end
            end
            OP_CAPTURE: begin
               if (enabled_ff && !pending_ff) begin
                  capture_in = cmd.hw_count;
                  pending_in = 1'b1;
               end
            end
            OP_SET: begin
               change    = new_offset - offset_ff;
               offset_in = new_offset;
            end
            OP_ADD: begin
               offset_in = offset_ff + cmd.value;
            end
            OP_ENABLE: begin
               last_hw_in = cmd.hw_count;
               seed_in    = sext16(cmd.hw_count);
               ring_clear = 1'b1;
               ptr_in     = '0;
               diff_in    = '0;
               enabled_in = 1'b1;
            end
            OP_DISABLE: begin
               enabled_in = 1'b0;
               seen_in    = 1'b0;
               pending_in = 1'b0;
               diff_in    = '0;
            end
            default: ;
         endcase
      end
   end

   // Keep the ring head pointing at the entry the next tick will replace
   assign rd_addr = ring_we ? ptr_next : (ring_clear ? '0 : ptr_ff);

   always_comb begin
      snap_in.accum         = accum_in;
      snap_in.offset        = offset_in;
      snap_in.index_base    = base_in;
      snap_in.vel_diff      = diff_in;
      snap_in.index_seen    = seen_in;
      snap_in.steps         = steps_in;
      snap_in.offset_change = change;
   end

   // Hold state and control
   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff      <= '0;
         offset_ff     <= '0;
         last_hw_ff    <= '0;
         ptr_ff        <= '0;
         enabled_ff    <= 1'b0;
         pending_ff    <= 1'b0;
         capture_ff    <= '0;
         base_ff       <= '0;
         seen_ff       <= 1'b0;
         diff_ff       <= '0;
         steps_ff      <= '0;
         seed_ff       <= '0;
         head_valid_ff <= 1'b0;
         snap_valid_ff <= 1'b0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            ring_valid_ff[i] <= 1'b0;
         end
      end else begin
         accum_ff   <= accum_in;
         offset_ff  <= offset_in;
         last_hw_ff <= last_hw_in;
         ptr_ff     <= ptr_in;
         enabled_ff <= enabled_in;
         pending_ff <= pending_in;
         capture_ff <= capture_in;
         base_ff    <= base_in;
         seen_ff    <= seen_in;
         diff_ff    <= diff_in;
         steps_ff   <= steps_in;
         seed_ff    <= seed_in;
         if (!snap_valid_ff || snap_ready) begin
            snap_valid_ff <= fire;
         end
         // Drop all ring entries back to the seed on enable
         if (ring_clear) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
               ring_valid_ff[i] <= 1'b0;
            end
            head_valid_ff <= 1'b0;
         end else if (ring_we) begin
            ring_valid_ff[ptr_ff] <= 1'b1;
            head_valid_ff <= (rd_addr == ptr_ff) ? 1'b1 : ring_valid_ff[rd_addr];
         end else begin
            head_valid_ff <= ring_valid_ff[rd_addr];
         end
      end
   end

   // Ring memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ptr_ff] <= accum_tick;
      end
      if (ring_we && (rd_addr == ptr_ff)) begin
         head_data_ff <= accum_tick;
      end else begin
         head_data_ff <= ring_mem[rd_addr];
      end
   end

   // Capture the result snapshot
   always_ff @(posedge clock) begin
      if (fire) begin
         snap_ff <= snap_in;
      end
   end

   `ASSERT_CHECK(a_enable_restarts_ring, clock, reset,
      (fire && cmd.op == OP_ENABLE) |=> (ptr_ff == '0 && !head_valid_ff && diff_ff == '0))
   `ASSERT_CHECK(a_disable_clears_flags, clock, reset,
      (fire && cmd.op == OP_DISABLE) |=> (!enabled_ff && !seen_ff && !pending_ff))

endmodule

// ===== src/ept_output.sv =====
// ---------------------------------------------------------------------------
// Encoder tracker output stage
// Forms the reported sums and the scaled velocity in the result register.
// ---------------------------------------------------------------------------
module ept_output
   import ept_pkg::*;
#(
   parameter int HISTORY_DEPTH = 8,
   parameter int SAMPLE_RATE   = 5000
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         snap_valid,
   output logic         snap_ready,
   input  snap_type     snap,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata,
   output logic [0:0]   rsp_tuser
);

   localparam logic [31:0] VEL_SCALE = 32'(SAMPLE_RATE / HISTORY_DEPTH);

   logic         valid_ff;
   logic [31:0]  position_ff;
   logic [31:0]  index_pos_ff;
   logic [31:0]  velocity_ff;
   logic         detected_ff;
   logic [15:0]  steps_ff;
   logic [31:0]  change_ff;
   logic [31:0]  vel_product;
   logic         load;

   assign load        = snap_valid && (!valid_ff || rsp_tready);
   assign snap_ready  = !valid_ff || rsp_tready;
   assign vel_product = snap.vel_diff * VEL_SCALE;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!valid_ff || rsp_tready) begin
         valid_ff <= snap_valid;
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (load) begin
         position_ff  <= snap.accum + snap.offset;
         index_pos_ff <= snap.index_base + snap.offset;
         velocity_ff  <= vel_product;
         detected_ff  <= snap.index_seen;
         steps_ff     <= snap.steps;
         change_ff    <= snap.offset_change;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {change_ff, steps_ff, velocity_ff, index_pos_ff, position_ff};
   assign rsp_tuser  = detected_ff;

endmodule

// ===== src/encoder_position_velocity_tracker.sv =====
// Path: queue, execute snapshot register, result register; stalls can hold each.
// Throughput: one item per cycle while responses do not stall, set by the execute
// stage, with the ring memory read ahead, registered, at the next slot to replace.
// Reset: synchronous; the tracker state, queue pointers and ring valid flags clear
// together, so items are taken right after reset with no clearing pass.
// ---------------------------------------------------------------------------
// Encoder position and velocity tracker
// Extends a 16-bit quadrature count to a 32-bit position with offset, index
// capture and a ring-based velocity estimate.
// ---------------------------------------------------------------------------
module encoder_position_velocity_tracker
   import ept_pkg::*;
#(
   parameter int HISTORY_DEPTH = 8,
   parameter int SAMPLE_RATE   = 5000
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // hw_count[15:0], value[47:16]
   input  logic [2:0]   req_tuser,   // req_type[2:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata,   // position[31:0], index_position[63:32],
                                     // velocity[95:64], steps_last[111:96],
                                     // offset_change[143:112]
   output logic [0:0]   rsp_tuser    // index_detected[0]
);

   logic     q_push;
   logic     q_full;
   cmd_type  q_in_cmd;
   logic     q_pop;
   logic     q_valid;
   cmd_type  q_out_cmd;
   logic     snap_valid;
   logic     snap_ready;
   snap_type snap;

   ept_front u_front (
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_in_cmd)
   );

   ept_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_in_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_cmd   (q_out_cmd)
   );

   ept_exec #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_exec (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_valid),
      .cmd        (q_out_cmd),
      .cmd_pop    (q_pop),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap)
   );

   ept_output #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .SAMPLE_RATE   (SAMPLE_RATE)
   ) u_output (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Encoder tracker testbench
// Drives request items into the position and velocity tracker, with random
// gaps on the request side and random stalls on the response side. A directed
// table comes first, then weighted random traffic. Each response is compared
// field by field with its typed row or a behavioural tracker kept in step here.
// ---------------------------------------------------------------------------
module tb;
   import ept_pkg::*;

   localparam int HISTORY_DEPTH  = 8;
   localparam int SAMPLE_RATE    = 5000;
   localparam logic [31:0] VEL_SCALE = 32'(SAMPLE_RATE / HISTORY_DEPTH);
   localparam int RANDOM_ITEMS   = 800;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 10;

   // Request codes the block leaves unused
   localparam logic [2:0] REQ_SPARE_LO = 3'd6;
   localparam logic [2:0] REQ_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [31:0] position;
      logic [31:0] index_position;
      logic [31:0] velocity;
      logic        index_detected;
      logic [15:0] steps_last;
      logic [31:0] offset_change;
   } track_result_type;

   typedef struct packed {
      logic [2:0]       kind;
      logic [15:0]      hw;
      logic [31:0]      val;
      logic             typed;
      track_result_type result;
   } stim_row_type;

   localparam track_result_type UNTYPED = '0;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [47:0]   req_tdata = '0;   // hw_count[15:0], value[47:16]
   logic [2:0]    req_tuser = '0;   // req_type[2:0]
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [143:0]  rsp_tdata;        // position[31:0], index_position[63:32],
                                    // velocity[95:64], steps_last[111:96],
                                    // offset_change[143:112]
   logic [0:0]    rsp_tuser;        // index_detected[0]

   // Behavioural copy of the tracker state
   logic [31:0] trk_accum = '0;
   logic [31:0] trk_offset = '0;
   logic [15:0] trk_last_count = '0;
   logic [31:0] trk_ring [HISTORY_DEPTH];
   int          trk_slot = 0;
   bit          trk_enabled = 1'b0;
   bit          trk_pending = 1'b0;
   logic [15:0] trk_captured = '0;
   logic [31:0] trk_index_base = '0;
   bit          trk_index_seen = 1'b0;
   logic [31:0] trk_velocity = '0;
   logic [15:0] trk_steps = '0;

   track_result_type tracker_outputs_q [$];
   stim_row_type     directed_rows [$];
   int               mismatch_count = 0;
   int               idle_cycles = 0;
   int               stall_left = 0;
   bit               steady = 1'b0;

   encoder_position_velocity_tracker #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .SAMPLE_RATE   (SAMPLE_RATE)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < HISTORY_DEPTH; i++) trk_ring[i] = '0;
   end

   // Idle length: mostly none or short, now and then long
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Apply one request to the tracker copy and return the response it gives
   function automatic track_result_type advance_tracker(input logic [2:0] kind,
                                                        input logic [15:0] hw,
                                                        input logic [31:0] val);
      track_result_type res;
      logic [31:0]      change;
      logic [31:0]      new_offset;
      change = '0;
      case (kind)
         REQ_TICK: begin
            if (trk_enabled) begin
               trk_steps = hw - trk_last_count;
               trk_index_seen = trk_pending;
               if (trk_pending) begin
                  trk_index_base = trk_accum + {{16{trk_captured[15]}}, trk_captured}
                                   - {{16{trk_last_count[15]}}, trk_last_count};
                  trk_pending = 1'b0;
               end
               trk_last_count = hw;
               trk_accum = trk_accum + {{16{trk_steps[15]}}, trk_steps};
               trk_velocity = (trk_accum - trk_ring[trk_slot]) * VEL_SCALE;
               trk_ring[trk_slot] = trk_accum;
               trk_slot = (trk_slot + 1) % HISTORY_DEPTH;
            end
         end
         REQ_CAPTURE: begin
            if (trk_enabled && !trk_pending) begin
               trk_captured = hw;
               trk_pending = 1'b1;
            end
         end
         REQ_SET: begin
            new_offset = val - trk_accum;
            change = new_offset - trk_offset;
            trk_offset = new_offset;
         end
         REQ_ADD: begin
            trk_offset = trk_offset + val;
         end
         REQ_ENABLE: begin
            trk_last_count = hw;
            for (int i = 0; i < HISTORY_DEPTH; i++) trk_ring[i] = {{16{hw[15]}}, hw};
            trk_slot = 0;
            trk_velocity = '0;
            trk_enabled = 1'b1;
         end
         REQ_DISABLE: begin
            trk_enabled = 1'b0;
            trk_index_seen = 1'b0;
            trk_pending = 1'b0;
            trk_velocity = '0;
         end
         default: begin
         end
      endcase
      res.position       = trk_accum + trk_offset;
      res.index_position = trk_index_base + trk_offset;
      res.velocity       = trk_velocity;
      res.index_detected = trk_index_seen;
      res.steps_last     = trk_steps;
      res.offset_change  = change;
      return res;
   endfunction

   // Offer one request item, hold it until taken, then queue its response
   task automatic send_request(input logic [2:0] kind, input logic [15:0] hw,
                               input logic [31:0] val, input logic typed,
                               input track_result_type typed_result);
      int               gap;
      track_result_type predicted;
      gap = steady ? 0 : idle_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {val, hw};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = advance_tracker(kind, hw, val);
      tracker_outputs_q.push_back(typed ? typed_result : predicted);
   endtask

   // Lower valid and hold off until every queued response has come back
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker_outputs_q.size() != 0) @(posedge clock);
   endtask

   // Response side: random stalls, none during steady stretches
   always @(posedge clock) begin
      if (steady) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left <= idle_length();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each response item with the oldest prediction
   always @(posedge clock) begin
      track_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (tracker_outputs_q.size() == 0) begin
            $error("unexpected response item: no prediction waiting");
            mismatch_count = mismatch_count + 1;
         end else begin
            want = tracker_outputs_q.pop_front();
            if (rsp_tdata[31:0] !== want.position) begin
               $error("position: expected %h, actual %h", want.position, rsp_tdata[31:0]);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_tdata[63:32] !== want.index_position) begin
               $error("index_position: expected %h, actual %h",
                      want.index_position, rsp_tdata[63:32]);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_tdata[95:64] !== want.velocity) begin
               $error("velocity: expected %h, actual %h", want.velocity, rsp_tdata[95:64]);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_tdata[111:96] !== want.steps_last) begin
               $error("steps_last: expected %h, actual %h",
                      want.steps_last, rsp_tdata[111:96]);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_tdata[143:112] !== want.offset_change) begin
               $error("offset_change: expected %h, actual %h",
                      want.offset_change, rsp_tdata[143:112]);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_tuser[0] !== want.index_detected) begin
               $error("index_detected: expected %b, actual %b",
                      want.index_detected, rsp_tuser[0]);
               mismatch_count = mismatch_count + 1;
            end
         end
      end
   end

   // Watchdog: stop when no item moves on either side for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("encoder_position_velocity_tracker verification failed");
         $finish;
      end
   end

   initial begin
      stim_row_type row;
      logic [2:0]   kind;
      logic [15:0]  hw;
      logic [31:0]  val;
      logic [15:0]  sim_count;
      int           r;

      // Directed table; typed responses hold from reset with the block disabled
      directed_rows.push_back({REQ_TICK,     16'h1234, 32'h0000_0000, 1'b1, UNTYPED});
      directed_rows.push_back({REQ_CAPTURE,  16'h4321, 32'h0000_0000, 1'b1, UNTYPED});
      directed_rows.push_back({REQ_SPARE_LO, 16'h0000, 32'h0000_0000, 1'b1, UNTYPED});
      directed_rows.push_back({REQ_SPARE_HI, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, UNTYPED});
      directed_rows.push_back({REQ_SET, 16'h0000, 32'h7FFF_FFFF, 1'b1,
         {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 1'b0, 16'h0, 32'h7FFF_FFFF}});
      directed_rows.push_back({REQ_ADD, 16'h0000, 32'h0000_0001, 1'b1,
         {32'h8000_0000, 32'h8000_0000, 32'h0, 1'b0, 16'h0, 32'h0}});
      directed_rows.push_back({REQ_SET, 16'h0000, 32'h8000_0000, 1'b1,
         {32'h8000_0000, 32'h8000_0000, 32'h0, 1'b0, 16'h0, 32'h0}});
      directed_rows.push_back({REQ_SET, 16'h0000, 32'h0000_0000, 1'b1,
         {32'h0, 32'h0, 32'h0, 1'b0, 16'h0, 32'h8000_0000}});
      // Enabled: count wraps in both directions, index capture, ignored capture
      directed_rows.push_back({REQ_ENABLE,   16'h7FFF, 32'h0000_0000, 1'b0, UNTYPED});
      directed_rows.push_back({REQ_TICK,     16'h8000, 32'h0000_0000, 1'b0, UNTYPED});
      directed_rows.push_back({REQ_TICK,     16'h7FFF, 32'h0000_0000, 1'b0, UNTYPED});
      directed_rows.push_back({REQ_CAPTURE,  16'h0000, 32'h0000_0000, 1'b0, UNTYPED});
      directed_rows.push_back({REQ_CAPTURE,  16'h1111, 32'h0000_0000, 1'b0, UNTYPED});
      directed_rows.push_back({REQ_TICK,     16'h0010, 32'h0000_0000, 1'b0, UNTYPED});
      directed_rows.push_back({REQ_TICK,     16'hFFFF, 32'h0000_0000, 1'b0, UNTYPED});
      directed_rows.push_back({REQ_TICK,     16'h8000, 32'h0000_0000, 1'b0, UNTYPED});
      directed_rows.push_back({REQ_ADD,      16'h0000, 32'hFFFF_FFFF, 1'b0, UNTYPED});
      // Disabled: ticks ignored, set and add still act
      directed_rows.push_back({REQ_DISABLE,  16'h0000, 32'h0000_0000, 1'b0, UNTYPED});
      directed_rows.push_back({REQ_TICK,     16'h2222, 32'h0000_0000, 1'b0, UNTYPED});
      directed_rows.push_back({REQ_SET,      16'h0000, 32'h1234_5678, 1'b0, UNTYPED});
      directed_rows.push_back({REQ_ADD,      16'h0000, 32'h8000_0000, 1'b0, UNTYPED});
      // Disable drops a pending index
      directed_rows.push_back({REQ_ENABLE,   16'h8000, 32'h0000_0000, 1'b0, UNTYPED});
      directed_rows.push_back({REQ_CAPTURE,  16'h7FFF, 32'h0000_0000, 1'b0, UNTYPED});
      directed_rows.push_back({REQ_DISABLE,  16'h0000, 32'h0000_0000, 1'b0, UNTYPED});
      directed_rows.push_back({REQ_ENABLE,   16'hFFFF, 32'h0000_0000, 1'b0, UNTYPED});
      directed_rows.push_back({REQ_TICK,     16'h0001, 32'h0000_0000, 1'b0, UNTYPED});

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_request(row.kind, row.hw, row.val, row.typed, row.result);
      end

      // Random traffic: mostly enabled ticks with small count steps
      sim_count = 16'h0001;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 150 && n < 250);
         if (n == 500) drain_responses();
         r = $urandom_range(0, 99);
         hw = 16'($urandom_range(0, 65535));
         case ($urandom_range(0, 3))
            0: val = 32'h7FFF_FFFF;
            1: val = 32'h8000_0000;
            2: val = 32'($signed($urandom_range(0, 2000)) - 1000);
            default: val = $urandom;
         endcase
         if (!trk_enabled) begin
            if (r < 50) kind = REQ_ENABLE;
            else if (r < 65) kind = REQ_TICK;
            else if (r < 75) kind = REQ_SET;
            else if (r < 85) kind = REQ_ADD;
            else if (r < 90) kind = REQ_CAPTURE;
            else kind = r[0] ? REQ_SPARE_HI : REQ_SPARE_LO;
         end else begin
            if (r < 65) kind = REQ_TICK;
            else if (r < 75) kind = REQ_CAPTURE;
            else if (r < 81) kind = REQ_SET;
            else if (r < 87) kind = REQ_ADD;
            else if (r < 90) kind = REQ_ENABLE;
            else if (r < 94) kind = REQ_DISABLE;
            else if (r < 97) kind = r[0] ? REQ_SPARE_HI : REQ_SPARE_LO;
            else kind = REQ_TICK;
         end
         // Keep the count moving by small steps, with the odd wild jump
         if ((kind == REQ_TICK || kind == REQ_CAPTURE) && $urandom_range(0, 9) != 0) begin
            hw = sim_count + 16'($urandom_range(0, 400)) - 16'd200;
         end
         if (kind == REQ_TICK || kind == REQ_ENABLE) sim_count = hw;
         send_request(kind, hw, val, 1'b0, UNTYPED);
      end
      steady = 1'b0;

      drain_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && tracker_outputs_q.size() == 0) begin
         $display("encoder_position_velocity_tracker verification clean");
      end else begin
         $display("encoder_position_velocity_tracker verification failed");
      end
      $finish;
   end

endmodule
